// ----- rtl/core/tecp_pkg.sv -----
package tecp_pkg;

  // Screen geometry
  localparam int ROWS      = 32;
  localparam int COLS      = 80;
  localparam int TAB_WIDTH = 8;

  // Field widths fixed by the result format
  localparam int LINE_W  = 5;
  localparam int COL_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 4;

  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LIMIT = COL_W'(COLS);
  localparam logic [BYTE_W-1:0] ARG_MAX   = 8'd255;

  // Control characters and sequence bytes
  localparam logic [7:0] CH_BEL      = 8'h07;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_ESC      = 8'h1b;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3b;
  localparam logic [7:0] CH_LBRACKET = 8'h5b;
  localparam logic [7:0] C1_LO       = 8'h80;
  localparam logic [7:0] C1_END      = 8'ha0;

  // Final letters of a control sequence
  localparam logic [7:0] FIN_AT = 8'h40;
  localparam logic [7:0] FIN_A  = 8'h41;
  localparam logic [7:0] FIN_B  = 8'h42;
  localparam logic [7:0] FIN_C  = 8'h43;
  localparam logic [7:0] FIN_D  = 8'h44;
  localparam logic [7:0] FIN_E  = 8'h45;
  localparam logic [7:0] FIN_H  = 8'h48;
  localparam logic [7:0] FIN_J  = 8'h4a;
  localparam logic [7:0] FIN_K  = 8'h4b;
  localparam logic [7:0] FIN_L  = 8'h4c;
  localparam logic [7:0] FIN_M  = 8'h4d;
  localparam logic [7:0] FIN_P  = 8'h50;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_CSI  = 2'd2
  } phase_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE      = 4'd0,
    CMD_DRAW      = 4'd1,
    CMD_SCROLL    = 4'd2,
    CMD_BELL      = 4'd3,
    CMD_ERASE_ALL = 4'd4,
    CMD_ERASE_EOS = 4'd5,
    CMD_ERASE_EOL = 4'd6,
    CMD_INS_LINE  = 4'd7,
    CMD_DEL_LINE  = 4'd8,
    CMD_INS_CHAR  = 4'd9,
    CMD_DEL_CHAR  = 4'd10
  } cmd_t;

  typedef struct packed {
    phase_t              phase;
    logic [LINE_W-1:0]   line;
    logic [COL_W-1:0]    col;
    logic [1:0]          slot;
    logic [BYTE_W-1:0]   arg0;
    logic [BYTE_W-1:0]   arg1;
  } parse_state_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [BYTE_W-1:0]   glyph;
    logic [COL_W-1:0]    at_col;
    logic [LINE_W-1:0]   at_line;
    logic [BYTE_W-1:0]   count;
    logic [COL_W-1:0]    cur_col;
    logic [LINE_W-1:0]   cur_line;
  } result_t;

endpackage

// ----- rtl/core/tecp_step.sv -----
module tecp_step
  import tecp_pkg::*;
(
  input  parse_state_t      st,
  input  logic [BYTE_W-1:0] byte_in,
  output parse_state_t      st_nxt,
  output result_t           res
);

  logic              is_digit;
  logic              digit_ok;
  logic              is_final;
  logic              take_plain;
  phase_t            phase_nxt;
  logic              drawable;

  logic [BYTE_W-1:0] n_arg;
  logic [7:0]        col_p1;
  logic [COL_W-1:0]  col_inc;
  logic [8:0]        tab_stop;
  logic [COL_W-1:0]  col_tab;
  logic [LINE_W:0]   line_p1;
  logic [BYTE_W-1:0] h_col_raw;
  logic [COL_W-1:0]  h_col;
  logic [BYTE_W-1:0] h_line_raw;
  logic              up_ok;
  logic [8:0]        down_sum;
  logic [LINE_W-1:0] line_down;
  logic              left_ok;
  logic [8:0]        right_sum;
  logic [COL_W-1:0]  col_right;
  logic [BYTE_W-1:0] arg_cur;
  logic [11:0]       arg_prod;
  logic [BYTE_W-1:0] arg_acc;

  logic [LINE_W-1:0] line_nxt;
  logic [COL_W-1:0]  col_nxt;
  logic [1:0]        slot_nxt;
  logic [BYTE_W-1:0] arg0_nxt;
  logic [BYTE_W-1:0] arg1_nxt;

  // Byte classes
  assign is_digit = (byte_in >= CH_ZERO) && (byte_in <= CH_NINE);
  assign digit_ok = is_digit && (st.slot < 2'd2);
  assign drawable = ({1'b0, st.col} < 8'(COLS)) && (byte_in >= CH_SPACE) &&
                    !((byte_in >= C1_LO) && (byte_in < C1_END));

  always_comb begin
    unique case (byte_in) inside
      FIN_H, FIN_A, FIN_B, FIN_C, FIN_D, FIN_E,
      FIN_J, FIN_K, FIN_L, FIN_M, FIN_AT, FIN_P: is_final = 1'b1;
      default:                                   is_final = 1'b0;
    endcase
  end

  // Does this byte fall through to plain-text handling
  always_comb begin
    unique case (st.phase)
      PH_ESC:  take_plain = (byte_in != CH_LBRACKET);
      PH_CSI:  take_plain = !digit_ok && (byte_in != CH_SEMI) && !is_final;
      default: take_plain = 1'b1;
    endcase
  end

  // Parse phase next state
  always_comb begin
    if (take_plain) begin
      phase_nxt = (byte_in == CH_ESC) ? PH_ESC : PH_TEXT;
    end else begin
      unique case (st.phase)
        PH_ESC:  phase_nxt = PH_CSI;
        PH_CSI:  phase_nxt = is_final ? PH_TEXT : PH_CSI;
        default: phase_nxt = PH_TEXT;
      endcase
    end
  end

  // Cursor arithmetic candidates
  assign n_arg     = (st.arg0 != '0) ? st.arg0 : 8'd1;
  assign col_p1    = {1'b0, st.col} + 8'd1;
  assign col_inc   = (col_p1 > 8'(COLS)) ? COL_LIMIT : col_p1[COL_W-1:0];
  assign tab_stop  = 9'(({2'b00, st.col} / TAB_WIDTH + 1) * TAB_WIDTH);
  assign col_tab   = (tab_stop > 9'(COLS)) ? COL_LIMIT : tab_stop[COL_W-1:0];
  assign line_p1   = {1'b0, st.line} + 6'd1;

  assign h_col_raw  = (st.arg1 != '0) ? (st.arg1 - 8'd1) : 8'd0;
  assign h_col      = (h_col_raw > 8'(COLS)) ? COL_LIMIT : h_col_raw[COL_W-1:0];
  assign h_line_raw = (st.arg0 != '0) ? (st.arg0 - 8'd1) : 8'd0;

  assign up_ok     = (n_arg <= {3'b000, st.line});
  assign down_sum  = {1'b0, n_arg} + {4'b0000, st.line};
  assign line_down = (down_sum > 9'(ROWS - 1)) ? LAST_LINE : down_sum[LINE_W-1:0];
  assign left_ok   = (n_arg <= {1'b0, st.col});
  assign right_sum = {1'b0, n_arg} + {2'b00, st.col};
  assign col_right = (right_sum > 9'(COLS)) ? COL_LIMIT : right_sum[COL_W-1:0];

  // Decimal argument accumulate, saturating
  assign arg_cur  = (st.slot == 2'd0) ? st.arg0 : st.arg1;
  assign arg_prod = {4'b0000, arg_cur} * 12'd10 + {8'h00, byte_in[3:0] - CH_ZERO[3:0]};
  assign arg_acc  = (arg_prod > 12'd255) ? ARG_MAX : arg_prod[BYTE_W-1:0];

  // Cursor, arguments and result
  always_comb begin
    line_nxt    = st.line;
    col_nxt     = st.col;
    slot_nxt    = st.slot;
    arg0_nxt    = st.arg0;
    arg1_nxt    = st.arg1;
    res.cmd     = CMD_NONE;
    res.glyph   = '0;
    res.at_col  = '0;
    res.at_line = '0;
    res.count   = 8'd1;

    if (take_plain) begin
      case (byte_in)
        CH_ESC: begin
        end
        CH_LF: begin
          if (line_p1 >= 6'(ROWS)) begin
            line_nxt = LAST_LINE;
            res.cmd  = CMD_SCROLL;
          end else begin
            line_nxt = line_p1[LINE_W-1:0];
          end
          col_nxt = '0;
        end
        CH_CR:  col_nxt = '0;
        CH_TAB: col_nxt = col_tab;
        CH_BS: begin
          if (st.col != '0) col_nxt = st.col - 7'd1;
        end
        CH_BEL: res.cmd = CMD_BELL;
        default: begin
          if (drawable) begin
            res.cmd     = CMD_DRAW;
            res.glyph   = byte_in;
            res.at_col  = st.col;
            res.at_line = st.line;
          end
          col_nxt = col_inc;
        end
      endcase
    end else begin
      unique case (st.phase)
        PH_ESC: begin
          arg0_nxt = '0;
          arg1_nxt = '0;
          slot_nxt = '0;
        end
        PH_CSI: begin
          if (digit_ok) begin
            if (st.slot == 2'd0) arg0_nxt = arg_acc;
            else arg1_nxt = arg_acc;
          end else if (byte_in == CH_SEMI) begin
            if (st.slot != 2'd3) slot_nxt = st.slot + 2'd1;
          end else begin
            case (byte_in)
              FIN_H: begin
                col_nxt = h_col;
                if (h_line_raw < 8'(ROWS)) line_nxt = h_line_raw[LINE_W-1:0];
              end
              FIN_A: begin
                if (up_ok) line_nxt = st.line - n_arg[LINE_W-1:0];
              end
              FIN_B: line_nxt = line_down;
              FIN_D: begin
                if (left_ok) col_nxt = st.col - n_arg[COL_W-1:0];
              end
              FIN_C: col_nxt = col_right;
              FIN_E: begin
                res.cmd  = CMD_ERASE_ALL;
                line_nxt = '0;
                col_nxt  = '0;
              end
              FIN_J: begin
                if (st.arg0 == 8'd2) begin
                  res.cmd  = CMD_ERASE_ALL;
                  line_nxt = '0;
                  col_nxt  = '0;
                end else begin
                  res.cmd     = CMD_ERASE_EOS;
                  res.at_col  = st.col;
                  res.at_line = st.line;
                end
              end
              FIN_K: begin
                res.cmd     = CMD_ERASE_EOL;
                res.at_col  = st.col;
                res.at_line = st.line;
              end
              FIN_L: begin
                res.cmd     = CMD_INS_LINE;
                res.at_col  = st.col;
                res.at_line = st.line;
                col_nxt     = '0;
              end
              FIN_M: begin
                res.cmd     = CMD_DEL_LINE;
                res.at_col  = st.col;
                res.at_line = st.line;
                col_nxt     = '0;
              end
              FIN_AT: begin
                res.cmd     = CMD_INS_CHAR;
                res.at_col  = st.col;
                res.at_line = st.line;
                res.count   = n_arg;
              end
              // delete chars
              default: begin
                res.cmd     = CMD_DEL_CHAR;
                res.at_col  = st.col;
                res.at_line = st.line;
                res.count   = n_arg;
              end
            endcase
          end
        end
        default: begin
        end
      endcase
    end

    res.cur_col  = col_nxt;
    res.cur_line = line_nxt;
  end

  assign st_nxt = '{phase: phase_nxt, line: line_nxt, col: col_nxt,
                    slot: slot_nxt, arg0: arg0_nxt, arg1: arg1_nxt};

endmodule

// ----- rtl/core/terminal_escape_cursor_parser.sv -----
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  in_byte_in[7:0]
// out_     out  out_valid/out_stall command, glyph, at col/line, count, cursor col/line
//
// One byte per cycle while the output is not stalled; a byte transfers into the
// input register, passes once through the parse logic and moves into the result
// register, from which its result transfers.
// The parse state updates in the same cycle the byte moves into the result
// register, so consecutive bytes follow with no gap.
// Synchronous active-low reset: text phase, cursor at column 0 of the last line.
// A stalled result holds; the input register still takes a byte while empty.
module terminal_escape_cursor_parser
  import tecp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CMD_W-1:0]  out_command,
  output logic [BYTE_W-1:0] out_glyph_code,
  output logic [COL_W-1:0]  out_at_column,
  output logic [LINE_W-1:0] out_at_line,
  output logic [BYTE_W-1:0] out_repeat_count,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [LINE_W-1:0] out_cursor_line
);

  logic              in_valid_r;
  logic [BYTE_W-1:0] byte_r;
  parse_state_t      st_r;
  parse_state_t      st_nxt;
  result_t           res_nxt;
  result_t           res_r;
  logic              out_valid_r;
  logic              out_ready;
  logic              advance;

  // Handshake control
  assign out_ready = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_ready;
  assign in_stall  = in_valid_r && !out_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) byte_r <= in_byte_in;
  end

  // Parse logic
  tecp_step u_step (
    .st      (st_r),
    .byte_in (byte_r),
    .st_nxt  (st_nxt),
    .res     (res_nxt)
  );

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_TEXT, line: LAST_LINE, col: '0, slot: '0,
                arg0: '0, arg1: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_command       = res_r.cmd;
  assign out_glyph_code    = res_r.glyph;
  assign out_at_column     = res_r.at_col;
  assign out_at_line       = res_r.at_line;
  assign out_repeat_count  = res_r.count;
  assign out_cursor_column = res_r.cur_col;
  assign out_cursor_line   = res_r.cur_line;

  // Checks
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_column <= COL_LIMIT))
    else $error("cursor column beyond screen width");

  a_draw_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_command == CMD_DRAW)) |->
      ((out_at_column < COL_LIMIT) && (out_glyph_code >= CH_SPACE)))
    else $error("draw outside screen or of a control byte");

  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_repeat_count != '0))
    else $error("zero repeat count");

  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_ready) |=> (in_valid_r && $stable(byte_r) && $stable(st_r)))
    else $error("pending byte or parse state lost under stall");

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import tecp_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SCRIPT_LEN   = 29;
  localparam int HOLD_CYCLES  = 120;

  // Directed row: byte to send, and the result typed in where it is obvious
  typedef struct {
    logic [7:0] code;
    bit         pinned;
    result_t    want;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte_in = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CMD_W-1:0]  out_command;
  logic [BYTE_W-1:0] out_glyph_code;
  logic [COL_W-1:0]  out_at_column;
  logic [LINE_W-1:0] out_at_line;
  logic [BYTE_W-1:0] out_repeat_count;
  logic [COL_W-1:0]  out_cursor_column;
  logic [LINE_W-1:0] out_cursor_line;

  // Typed result that travels with the byte in flight
  bit      in_pinned = 1'b0;
  result_t in_pinned_res = '0;

  // Parser tracker state
  phase_t            trk_phase;
  logic [LINE_W-1:0] trk_line;
  logic [COL_W-1:0]  trk_col;
  logic [1:0]        trk_slot;
  logic [BYTE_W-1:0] trk_arg0;
  logic [BYTE_W-1:0] trk_arg1;

  result_t pending_cmds [$];
  result_t predicted;
  result_t oldest;
  int      mismatches = 0;
  int      cycle_cnt = 0;
  int      bytes_sent = 0;
  bit      calm = 1'b0;
  bit      rx_hold_req = 1'b0;

  logic [7:0] final_letters [12] = '{FIN_H, FIN_A, FIN_B, FIN_C, FIN_D, FIN_E,
                                     FIN_J, FIN_K, FIN_L, FIN_M, FIN_AT, FIN_P};

  script_row_t script [SCRIPT_LEN] = '{
    '{8'h41, 1'b1, '{CMD_DRAW, 8'h41, 7'd0, 5'd31, 8'd1, 7'd1, 5'd31}},
    '{CH_BEL, 1'b1, '{CMD_BELL, 8'h00, 7'd0, 5'd0, 8'd1, 7'd1, 5'd31}},
    '{CH_LF, 1'b1, '{CMD_SCROLL, 8'h00, 7'd0, 5'd0, 8'd1, 7'd0, 5'd31}},
    '{8'hff, 1'b1, '{CMD_DRAW, 8'hff, 7'd0, 5'd31, 8'd1, 7'd1, 5'd31}},
    '{8'h9f, 1'b1, '{CMD_NONE, 8'h00, 7'd0, 5'd0, 8'd1, 7'd2, 5'd31}},
    '{8'h00, 1'b1, '{CMD_NONE, 8'h00, 7'd0, 5'd0, 8'd1, 7'd3, 5'd31}},
    '{CH_TAB, 1'b0, '0},
    '{CH_BS, 1'b0, '0},
    // ESC [ 999 ; 3 H: argument saturates, out-of-range line ignored
    '{CH_ESC, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_NINE, 1'b0, '0},
    '{CH_SEMI, 1'b0, '0},
    '{CH_ZERO + 8'd3, 1'b0, '0},
    '{FIN_H, 1'b0, '0},
    // ESC [ P: no argument gives a count of one
    '{CH_ESC, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, '0},
    '{FIN_P, 1'b0, '0},
    // ESC [ 2 J: erase screen and home
    '{CH_ESC, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, '0},
    '{CH_ZERO + 8'd2, 1'b0, '0},
    '{FIN_J, 1'b1, '{CMD_ERASE_ALL, 8'h00, 7'd0, 5'd0, 8'd1, 7'd0, 5'd0}},
    // unknown byte after ESC falls back to text
    '{CH_ESC, 1'b0, '0},
    '{8'h71, 1'b0, '0},
    // digit in the third argument slot ends the sequence
    '{CH_ESC, 1'b0, '0},
    '{CH_LBRACKET, 1'b0, '0},
    '{CH_SEMI, 1'b0, '0},
    '{CH_SEMI, 1'b0, '0}
  };

  terminal_escape_cursor_parser dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_in       (in_byte_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_command      (out_command),
    .out_glyph_code   (out_glyph_code),
    .out_at_column    (out_at_column),
    .out_at_line      (out_at_line),
    .out_repeat_count (out_repeat_count),
    .out_cursor_column(out_cursor_column),
    .out_cursor_line  (out_cursor_line)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- tracker
  function automatic logic [COL_W-1:0] clamp_col(input int v);
    return (v > COLS) ? COL_LIMIT : COL_W'(v);
  endfunction

  task automatic stamp(inout result_t r, input cmd_t k);
    r.cmd     = k;
    r.at_col  = trk_col;
    r.at_line = trk_line;
  endtask

  task automatic track_text(input logic [7:0] c, inout result_t r);
    case (c)
      CH_ESC: trk_phase = PH_ESC;
      CH_LF: begin
        if (int'(trk_line) + 1 >= ROWS) begin
          trk_line = LAST_LINE;
          r.cmd    = CMD_SCROLL;
        end else begin
          trk_line = trk_line + 1'b1;
        end
        trk_col = '0;
      end
      CH_CR:  trk_col = '0;
      CH_TAB: trk_col = clamp_col((int'(trk_col) / TAB_WIDTH + 1) * TAB_WIDTH);
      CH_BS:  if (trk_col != '0) trk_col = trk_col - 1'b1;
      CH_BEL: r.cmd = CMD_BELL;
      default: begin
        // C0 and C1 controls still advance the column
        if (int'(trk_col) < COLS && c >= CH_SPACE && !(c >= C1_LO && c < C1_END)) begin
          stamp(r, CMD_DRAW);
          r.glyph = c;
        end
        trk_col = clamp_col(int'(trk_col) + 1);
      end
    endcase
  endtask

  task automatic track_letter(input logic [7:0] c, inout result_t r);
    int n;
    int t;
    n = (trk_arg0 != '0) ? int'(trk_arg0) : 1;
    trk_phase = PH_TEXT;
    case (c)
      FIN_H: begin
        trk_col = clamp_col((trk_arg1 != '0) ? int'(trk_arg1) - 1 : 0);
        t = (trk_arg0 != '0) ? int'(trk_arg0) - 1 : 0;
        if (t < ROWS) trk_line = LINE_W'(t);
      end
      FIN_A: if (n <= int'(trk_line)) trk_line = LINE_W'(int'(trk_line) - n);
      FIN_B: begin
        t = int'(trk_line) + n;
        trk_line = (t > ROWS - 1) ? LAST_LINE : LINE_W'(t);
      end
      FIN_D: if (n <= int'(trk_col)) trk_col = COL_W'(int'(trk_col) - n);
      FIN_C: trk_col = clamp_col(int'(trk_col) + n);
      FIN_E: begin
        r.cmd    = CMD_ERASE_ALL;
        trk_line = '0;
        trk_col  = '0;
      end
      FIN_J: begin
        if (trk_arg0 == 8'd2) begin
          r.cmd    = CMD_ERASE_ALL;
          trk_line = '0;
          trk_col  = '0;
        end else begin
          stamp(r, CMD_ERASE_EOS);
        end
      end
      FIN_K: stamp(r, CMD_ERASE_EOL);
      FIN_L: begin
        stamp(r, CMD_INS_LINE);
        trk_col = '0;
      end
      FIN_M: begin
        stamp(r, CMD_DEL_LINE);
        trk_col = '0;
      end
      FIN_AT: begin
        stamp(r, CMD_INS_CHAR);
        r.count = BYTE_W'(n);
      end
      default: begin
        stamp(r, CMD_DEL_CHAR);
        r.count = BYTE_W'(n);
      end
    endcase
  endtask

  // One byte in, one screen command and cursor position out
  task automatic parse_terminal_byte(input logic [7:0] c, output result_t r);
    int v;
    r = '0;
    r.cmd   = CMD_NONE;
    r.count = 8'd1;
    case (trk_phase)
      PH_ESC: begin
        if (c == CH_LBRACKET) begin
          trk_arg0  = '0;
          trk_arg1  = '0;
          trk_slot  = '0;
          trk_phase = PH_CSI;
        end else begin
          trk_phase = PH_TEXT;
          track_text(c, r);
        end
      end
      PH_CSI: begin
        if (c >= CH_ZERO && c <= CH_NINE && trk_slot < 2'd2) begin
          v = int'((trk_slot == '0) ? trk_arg0 : trk_arg1) * 10 + int'(c - CH_ZERO);
          if (v > int'(ARG_MAX)) v = int'(ARG_MAX);
          if (trk_slot == '0) trk_arg0 = BYTE_W'(v);
          else trk_arg1 = BYTE_W'(v);
        end else if (c == CH_SEMI) begin
          if (trk_slot < 2'd3) trk_slot = trk_slot + 1'b1;
        end else if (c inside {FIN_H, FIN_A, FIN_B, FIN_C, FIN_D, FIN_E,
                               FIN_J, FIN_K, FIN_L, FIN_M, FIN_AT, FIN_P}) begin
          track_letter(c, r);
        end else begin
          trk_phase = PH_TEXT;
          track_text(c, r);
        end
      end
      default: begin
        trk_phase = PH_TEXT;
        track_text(c, r);
      end
    endcase
    r.cur_col  = trk_col;
    r.cur_line = trk_line;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Sample both channels at the edge; every transfer is seen here
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        parse_terminal_byte(in_byte_in, predicted);
        pending_cmds.push_back(in_pinned ? in_pinned_res : predicted);
      end
      if (out_valid && !out_stall) begin
        if (pending_cmds.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending, command %0d", out_command));
        end else begin
          oldest = pending_cmds.pop_front();
          check_field("command", int'(out_command), int'(oldest.cmd));
          check_field("glyph_code", int'(out_glyph_code), int'(oldest.glyph));
          check_field("at_column", int'(out_at_column), int'(oldest.at_col));
          check_field("at_line", int'(out_at_line), int'(oldest.at_line));
          check_field("repeat_count", int'(out_repeat_count), int'(oldest.count));
          check_field("cursor_column", int'(out_cursor_column), int'(oldest.cur_col));
          check_field("cursor_line", int'(out_cursor_line), int'(oldest.cur_line));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- receiver
  initial begin : rx_side
    int run;
    int hold;
    int pick;
    @(posedge rst_n);
    forever begin
      if (rx_hold_req) begin
        // long back-pressure so the pipe fills and stalls the input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
        out_stall <= 1'b0;
        repeat (run) @(posedge clk);
        pick = $urandom_range(0, 99);
        hold = (pick < 50) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(15, 40);
        if (hold > 0) begin
          out_stall <= 1'b1;
          repeat (hold) @(posedge clk);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sender
  function automatic int pick_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one byte and hold it until the transfer happens
  task automatic put_byte(input logic [7:0] b, input bit pin = 1'b0,
                          input result_t pres = '0);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte_in    <= b;
    in_pinned     <= pin;
    in_pinned_res <= pres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic put_digits(input int count);
    repeat (count) put_byte(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  initial begin : tx_side
    int kind;
    int sub;
    int nargs;
    int block;
    bit hold_done;
    bit drain_done;

    hold_done  = 1'b0;
    drain_done = 1'b0;
    block      = 0;
    trk_phase  = PH_TEXT;
    trk_line   = LAST_LINE;
    trk_col    = '0;
    trk_slot   = '0;
    trk_arg0   = '0;
    trk_arg1   = '0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed bytes
    for (int i = 0; i < SCRIPT_LEN; i++)
      put_byte(script[i].code, script[i].pinned, script[i].want);
    put_byte(CH_ZERO + 8'd7);

    // Random mix: well-formed sequences most often, some text, some broken
    while (bytes_sent < SCRIPT_LEN + 1 + RANDOM_ITEMS) begin
      if (bytes_sent / 100 != block) begin
        block = bytes_sent / 100;
        calm  = ($urandom_range(0, 3) == 0);
      end
      if (!hold_done && bytes_sent >= 400) begin
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        calm        = 1'b1;
      end
      if (!drain_done && bytes_sent >= 900) begin
        // sender waits until every pending command has come out
        drain_done = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_cmds.size() != 0) @(posedge clk);
      end

      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        repeat ($urandom_range(1, 12)) begin
          sub = $urandom_range(0, 11);
          case (sub)
            0: put_byte(CH_LF);
            1: put_byte(CH_CR);
            2: put_byte(CH_TAB);
            3: put_byte(CH_BS);
            4: put_byte(CH_BEL);
            5: put_byte(8'($urandom_range(0, 255)));
            default: put_byte(8'($urandom_range(32, 255)));
          endcase
        end
      end else if (kind < 82) begin
        put_byte(CH_ESC);
        put_byte(CH_LBRACKET);
        nargs = $urandom_range(0, 2);
        for (int a = 0; a < nargs; a++) begin
          put_digits($urandom_range(0, 3));
          if (a < nargs - 1) put_byte(CH_SEMI);
        end
        put_byte(final_letters[$urandom_range(0, 11)]);
      end else if (kind < 92) begin
        sub = $urandom_range(0, 3);
        case (sub)
          0: begin
            put_byte(CH_ESC);
            put_byte(8'($urandom_range(0, 255)));
          end
          1: begin
            put_byte(CH_ESC);
            put_byte(CH_LBRACKET);
            put_digits($urandom_range(1, 2));
            put_byte(8'($urandom_range(0, 255)));
          end
          2: begin
            put_byte(CH_ESC);
            put_byte(CH_LBRACKET);
            repeat ($urandom_range(2, 4)) put_byte(CH_SEMI);
            put_digits($urandom_range(1, 2));
            put_byte(final_letters[$urandom_range(0, 11)]);
          end
          default: begin
            put_byte(CH_ESC);
            put_byte(CH_ESC);
            put_byte(CH_LBRACKET);
            put_digits($urandom_range(0, 2));
            put_byte(final_letters[$urandom_range(0, 11)]);
          end
        endcase
      end else begin
        put_byte(8'($urandom_range(0, 255)));
      end
    end

    // Drain and let the pipe settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/tecp_pkg.sv
rtl/core/tecp_step.sv
rtl/core/terminal_escape_cursor_parser.sv
dv/testbench.sv
